// ===== design/vialu_pkg.sv =====
// ============================================================================
// vialu_pkg: shared types and constants for the vector integer ALU executor
// Instruction codes, item kinds, status codes and the instruction decoder.
// ============================================================================
`default_nettype none

package vialu_pkg;

  // Default sizing
  localparam int VIALU_VECTOR_BITS = 256;
  localparam int VIALU_ELEMS_PER_REG = 256;
  localparam int VIALU_REG_COUNT = 32;
  localparam int VIALU_REG_W = 5;
  localparam int VIALU_AVL_W = 10;
  localparam int VIALU_CFG_W = 10;

  // Instruction encoding
  localparam logic [6:0] OPC_VECTOR = 7'b1010111;
  localparam logic [5:0] F6_VADD = 6'b000000;
  localparam logic [5:0] F6_VSUB = 6'b000010;
  localparam logic [5:0] F6_VRSUB = 6'b000011;
  localparam logic [5:0] F6_VAND = 6'b001001;
  localparam logic [5:0] F6_VOR = 6'b001010;
  localparam logic [5:0] F6_VXOR = 6'b001011;
  localparam logic [2:0] F3_OPIVV = 3'b000;
  localparam logic [2:0] F3_OPIVI = 3'b011;

  // vtype codes
  localparam logic [2:0] SEW_CODE_8 = 3'd0;
  localparam logic [2:0] SEW_CODE_16 = 3'd1;
  localparam logic [2:0] SEW_CODE_32 = 3'd2;
  localparam logic [2:0] LMUL_CODE_1 = 3'd0;
  localparam logic [2:0] LMUL_CODE_2 = 3'd1;
  localparam logic [2:0] LMUL_CODE_4 = 3'd2;
  localparam logic [2:0] LMUL_CODE_8 = 3'd3;
  localparam logic [2:0] LMUL_CODE_HALF = 3'd7;

  typedef enum logic [1:0] {
    KIND_EXEC  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_READ    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_AVL  = 2'd0,
    CFG_SEW  = 2'd1,
    CFG_LMUL = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_RSUB,
    ALU_AND,
    ALU_OR,
    ALU_XOR
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    alu_op_t     op;
    logic        use_imm;
    logic [31:0] imm;
  } alu_ctl_t;

  typedef struct packed {
    logic    legal;
    alu_ctl_t ctl;
  } dec_t;

  typedef struct packed {
    logic [VIALU_AVL_W-1:0] avl;
    logic [2:0]             sew_code;
    logic [2:0]             lmul_code;
  } vcfg_t;

  typedef struct packed {
    logic        load;
    logic [31:0] data;
    status_t     status;
  } res_t;

  function automatic dec_t decode(logic [31:0] w);
    dec_t d;
    logic [5:0] f6;
    logic [2:0] f3;
    f6 = w[31:26];
    f3 = w[14:12];
    d.legal = 1'b1;
    d.ctl.op = ALU_ADD;
    d.ctl.use_imm = 1'b0;
    d.ctl.imm = {{27{w[19]}}, w[19:15]};
    if (w[6:0] != OPC_VECTOR) begin
      d.legal = 1'b0;
    end else if (f6 == F6_VADD && f3 == F3_OPIVV) begin
      d.ctl.op = ALU_ADD;
    end else if (f6 == F6_VADD && f3 == F3_OPIVI) begin
      d.ctl.op = ALU_ADD;
      d.ctl.use_imm = 1'b1;
    end else if (f6 == F6_VSUB && f3 == F3_OPIVV) begin
      d.ctl.op = ALU_SUB;
    end else if (f6 == F6_VRSUB && f3 == F3_OPIVI) begin
      d.ctl.op = ALU_RSUB;
      d.ctl.use_imm = 1'b1;
    end else if (f6 == F6_VAND && f3 == F3_OPIVV) begin
      d.ctl.op = ALU_AND;
    end else if (f6 == F6_VOR && f3 == F3_OPIVV) begin
      d.ctl.op = ALU_OR;
    end else if (f6 == F6_VXOR && f3 == F3_OPIVV) begin
      d.ctl.op = ALU_XOR;
    end else begin
      d.legal = 1'b0;
    end
    // masked forms are not supported
    if (!w[25]) begin
      d.legal = 1'b0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== design/vialu_regfile.sv =====
// ============================================================================
// vialu_regfile: vector register file storage
// One write port and two read ports, read data registered.
// ============================================================================
`default_nettype none

module vialu_regfile #(
  parameter int ADDR_W = 13
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [31:0]       wdata,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [31:0]       rdata_a,
  output logic      [31:0]       rdata_b
);

  logic [31:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== design/vialu_alu.sv =====
// ============================================================================
// vialu_alu: shared element ALU
// Add, subtract, reverse subtract and bitwise ops on one 32-bit element.
// ============================================================================
`default_nettype none

module vialu_alu
  import vialu_pkg::*;
(
  input  wire alu_ctl_t    ctl,
  input  wire logic [31:0] vs2_data,
  input  wire logic [31:0] vs1_data,
  output logic      [31:0] result
);

  logic [31:0] b;

  assign b = ctl.use_imm ? ctl.imm : vs1_data;

  always_comb begin
    case (ctl.op)
      ALU_ADD:  result = vs2_data + b;
      ALU_SUB:  result = vs2_data - b;
      ALU_RSUB: result = b - vs2_data;
      ALU_AND:  result = vs2_data & b;
      ALU_OR:   result = vs2_data | b;
      ALU_XOR:  result = vs2_data ^ b;
      default:  result = vs2_data + b;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/vialu_ctrl.sv =====
// ============================================================================
// vialu_ctrl: sequencer for the vector ALU executor
// Clearing pass, item dispatch, VL computation and the element loop.
// ============================================================================
`default_nettype none

module vialu_ctrl
  import vialu_pkg::*;
#(
  parameter int VECTOR_BITS = VIALU_VECTOR_BITS,
  parameter int ELEMS_PER_REGISTER = VIALU_ELEMS_PER_REG,
  localparam int EW = $clog2(ELEMS_PER_REGISTER),
  localparam int AW = VIALU_REG_W + EW
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic [1:0]             kind,
  input  wire logic [31:0]            instr_word,
  input  wire logic [VIALU_REG_W-1:0] reg_index,
  input  wire logic [7:0]             elem_index,
  input  wire logic [31:0]            write_data,
  input  wire vcfg_t                  vcfg,
  input  wire logic                   out_busy,
  input  wire logic [31:0]            rdata_a,
  input  wire logic [31:0]            alu_res,
  output logic                        in_stall,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [31:0]                 mem_wdata,
  output logic [AW-1:0]               mem_raddr_a,
  output logic [AW-1:0]               mem_raddr_b,
  output alu_ctl_t                    alu_ctl,
  output res_t                        res
);

  localparam int VM_W = $clog2(VECTOR_BITS + 1);
  localparam int CMP_A = (VM_W > VIALU_AVL_W) ? VM_W : VIALU_AVL_W;
  localparam int CMP_W = (CMP_A > EW + 1) ? CMP_A : EW + 1;
  localparam int EXT_W = (EW > 8) ? EW : 8;

  state_t                 state, state_next;
  logic [AW-1:0]          clr_addr, clr_addr_next;
  logic [EW:0]            rd_idx, rd_idx_next, rd_idx_inc;
  logic                   p1_valid, p1_valid_next;
  logic [EW-1:0]          p1_idx;
  logic                   rd_oob, rd_oob_next;
  logic [EW:0]            vl_q;
  logic [VIALU_REG_W-1:0] vd_q, vs2_q, vs1_q;
  alu_ctl_t               ctl_q;

  logic                   accept;
  logic                   in_range;
  logic [EXT_W-1:0]       elem_ext;
  logic [EW-1:0]          elem_addr;
  dec_t                   dec;
  logic [CMP_W-1:0]       vl_base, vlmax, vl_avl, vl_full;
  logic [EW:0]            vl_calc;
  logic                   start_run;

  assign elem_ext = EXT_W'(elem_index);
  assign elem_addr = elem_ext[EW-1:0];
  assign in_range = (32'(elem_index) < ELEMS_PER_REGISTER);
  assign dec = decode(instr_word);
  assign rd_idx_inc = rd_idx + 1'b1;
  assign alu_ctl = ctl_q;

  // VL = min(AVL, VLMAX, elements per register)
  always_comb begin
    case (vcfg.sew_code)
      SEW_CODE_8:  vl_base = CMP_W'(VECTOR_BITS / 8);
      SEW_CODE_16: vl_base = CMP_W'(VECTOR_BITS / 16);
      default:     vl_base = CMP_W'(VECTOR_BITS / 32);
    endcase
    case (vcfg.lmul_code)
      LMUL_CODE_2:    vlmax = vl_base << 1;
      LMUL_CODE_4:    vlmax = vl_base << 2;
      LMUL_CODE_8:    vlmax = vl_base << 3;
      LMUL_CODE_HALF: vlmax = vl_base >> 1;
      default:        vlmax = vl_base;
    endcase
    vl_avl = (CMP_W'(vcfg.avl) < vlmax) ? CMP_W'(vcfg.avl) : vlmax;
    vl_full = (vl_avl < CMP_W'(ELEMS_PER_REGISTER)) ? vl_avl
                                                    : CMP_W'(ELEMS_PER_REGISTER);
    vl_calc = vl_full[EW:0];
  end

  assign in_stall = (state != ST_IDLE) || out_busy;
  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    clr_addr_next = clr_addr;
    rd_idx_next = rd_idx;
    rd_oob_next = rd_oob;
    p1_valid_next = (state == ST_RUN);
    start_run = 1'b0;
    mem_we = p1_valid;
    mem_waddr = {vd_q, p1_idx};
    mem_wdata = alu_res;
    mem_raddr_a = {vs2_q, rd_idx[EW-1:0]};
    mem_raddr_b = {vs1_q, rd_idx[EW-1:0]};
    res.load = 1'b0;
    res.data = '0;
    res.status = STAT_DONE;

    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_raddr_a = {reg_index, elem_addr};
        if (accept) begin
          case (kind)
            KIND_WRITE: begin
              mem_we = in_range;
              mem_waddr = {reg_index, elem_addr};
              mem_wdata = write_data;
              res.load = 1'b1;
            end
            KIND_READ: begin
              rd_oob_next = !in_range;
              state_next = ST_READ;
            end
            KIND_EXEC: begin
              if (!dec.legal) begin
                res.load = 1'b1;
                res.status = STAT_IGNORED;
              end else if (vl_calc == '0) begin
                res.load = 1'b1;
              end else begin
                start_run = 1'b1;
                rd_idx_next = '0;
                state_next = ST_RUN;
              end
            end
            default: begin
              res.load = 1'b1;
              res.status = STAT_IGNORED;
            end
          endcase
        end
      end
      ST_READ: begin
        res.load = 1'b1;
        res.data = rd_oob ? '0 : rdata_a;
        res.status = STAT_READ;
        state_next = ST_IDLE;
      end
      ST_RUN: begin
        rd_idx_next = rd_idx_inc;
        if (rd_idx_inc == vl_q) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        res.load = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      rd_idx <= '0;
      p1_valid <= 1'b0;
      rd_oob <= 1'b0;
    end else begin
      state <= state_next;
      clr_addr <= clr_addr_next;
      rd_idx <= rd_idx_next;
      p1_valid <= p1_valid_next;
      rd_oob <= rd_oob_next;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx <= rd_idx[EW-1:0];
    if (start_run) begin
      vl_q <= vl_calc;
      vd_q <= instr_word[11:7];
      vs2_q <= instr_word[24:20];
      vs1_q <= instr_word[19:15];
      ctl_q <= dec.ctl;
    end
  end

  // element loop never runs past VL
  a_run_in_bounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> rd_idx < vl_q)
    else $error("element counter past VL");

  // result register is free whenever a result is produced
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res.load |-> !out_busy)
    else $error("result produced while output register is held");

  // last element write coincides with the completion result
  a_drain_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> p1_valid && mem_we && res.load)
    else $error("drain without last element write");

  // the read state always returns to idle
  a_read_one: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> state == ST_IDLE)
    else $error("read did not return to idle");

endmodule

`default_nettype wire

// ===== design/vector_integer_alu_executor.sv =====
// ============================================================================
// vector_integer_alu_executor: reduced vector integer ALU
// 32 vector registers of 32-bit elements, add/sub/rsub/and/or/xor over VL
// elements, plus element write and read items.
// ============================================================================
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  -----------------------------------
//  in       sink       in_valid / in_stall    kind, instr_word, reg_index,
//                                             elem_index, write_data
//  out      source     out_valid / out_stall  read_data, status
//  cfg      sink       cfg_write_en           cfg_index, cfg_data
//
//  Sequence: write, ignored and zero-VL words finish at the accept edge and
//  load the output register there; a read passes through READ; an execute
//  loops in RUN over VL elements, then DRAIN, one element per cycle through
//  the register file's two read ports and one write port into the single ALU.
//  Reset: a clearing pass zeroes all 32 * 2**clog2(ELEMS_PER_REGISTER) entries
//  (8192 by default) of the register file, one element per cycle; input is
//  stalled meanwhile, configuration writes are taken.
//  Stalls: one output register; a new word is taken when idle and the output
//  register is empty or being drained.
//
`default_nettype none

module vector_integer_alu_executor
  import vialu_pkg::*;
#(
  parameter int VECTOR_BITS = VIALU_VECTOR_BITS,
  parameter int ELEMS_PER_REGISTER = VIALU_ELEMS_PER_REG
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input word channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             kind,
  input  wire logic [31:0]            instr_word,
  input  wire logic [VIALU_REG_W-1:0] reg_index,
  input  wire logic [7:0]             elem_index,
  input  wire logic [31:0]            write_data,
  // result word channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [31:0]                 read_data,
  output logic [1:0]                  status,
  // configuration write port
  input  wire logic                   cfg_write_en,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [VIALU_CFG_W-1:0] cfg_data
);

  localparam int EW = $clog2(ELEMS_PER_REGISTER);
  localparam int AW = VIALU_REG_W + EW;

  vcfg_t       vcfg;
  logic        out_busy;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [31:0] mem_wdata, rdata_a, rdata_b;
  logic [31:0] alu_res;
  alu_ctl_t    alu_ctl;
  res_t        res;

  // vtype / AVL registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vcfg.avl <= VIALU_AVL_W'(8);
      vcfg.sew_code <= SEW_CODE_32;
      vcfg.lmul_code <= LMUL_CODE_1;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_AVL:  vcfg.avl <= cfg_data[VIALU_AVL_W-1:0];
        CFG_SEW:  vcfg.sew_code <= cfg_data[2:0];
        CFG_LMUL: vcfg.lmul_code <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // output register: holds one result word until taken
  assign out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      read_data <= res.data;
      status <= res.status;
    end
  end

  vialu_ctrl #(
    .VECTOR_BITS        (VECTOR_BITS),
    .ELEMS_PER_REGISTER (ELEMS_PER_REGISTER)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .kind        (kind),
    .instr_word  (instr_word),
    .reg_index   (reg_index),
    .elem_index  (elem_index),
    .write_data  (write_data),
    .vcfg        (vcfg),
    .out_busy    (out_busy),
    .rdata_a     (rdata_a),
    .alu_res     (alu_res),
    .in_stall    (in_stall),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .alu_ctl     (alu_ctl),
    .res         (res)
  );

  // port a carries vs2 (and element reads), port b carries vs1
  vialu_regfile #(
    .ADDR_W (AW)
  ) u_regfile (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  vialu_alu u_alu (
    .ctl      (alu_ctl),
    .vs2_data (rdata_a),
    .vs1_data (rdata_b),
    .result   (alu_res)
  );

endmodule

`default_nettype wire
